>>> hw/rtl/gbn_pkg.sv
// Shared types, constants and codes for the go-back-N sender window.
package gbn_pkg;

	localparam int WINDOW_MAX  = 16;
	localparam int SLOT_W      = $clog2(WINDOW_MAX);
	localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
	localparam int SEQ_W       = 16;
	localparam int WORD_W      = 32;
	localparam int LEN_W       = 11;
	localparam int WIN_W       = 5;
	localparam int RETRY_W     = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W     = WORD_W + LEN_W;

	localparam logic [LEN_W-1:0]   CHUNK_MAX   = LEN_W'(1024);
	localparam logic [WIN_W-1:0]   WIN_RESET   = WIN_W'(4);
	localparam logic [RETRY_W-1:0] RETRY_RESET = RETRY_W'(10);
	localparam logic [RETRY_W-1:0] RETRY_SAT   = RETRY_W'(15);

	// Event codes on the input op field
	typedef enum logic [1:0] {
		OP_SEND    = 2'd0,
		OP_ACK     = 2'd1,
		OP_TIMEOUT = 2'd2
	} op_t;

	// Classified command handed from front to back
	typedef enum logic [1:0] {
		CMD_SEND,
		CMD_ACK,
		CMD_TIMEOUT,
		CMD_NOP
	} cmd_kind_t;

	typedef enum logic [1:0] {
		TMR_LEAVE = 2'd0,
		TMR_ARM   = 2'd1,
		TMR_STOP  = 2'd2
	} timer_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_FULL    = 2'd1,
		STS_FAIL    = 2'd2,
		STS_IGNORED = 2'd3
	} status_t;

	// Configuration register indexes
	typedef enum logic {
		REG_WIN_LIMIT   = 1'b0,
		REG_RETRY_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		S_IDLE,
		S_REPLAY
	} state_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [WORD_W-1:0] word;
		logic [LEN_W-1:0]  len;
		logic [SEQ_W-1:0]  ack;
	} cmd_t;

endpackage

>>> hw/rtl/gbn_front.sv
// Front end: accepts events, classifies them and queues them for the back end.
module gbn_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       evt_valid,
	output logic                       evt_stall,
	input  logic [1:0]                 op,
	input  logic [gbn_pkg::WORD_W-1:0] chunk_word,
	input  logic [gbn_pkg::LEN_W-1:0]  chunk_len,
	input  logic [gbn_pkg::SEQ_W-1:0]  ack_number,
	output logic                       cmd_valid,
	output gbn_pkg::cmd_t              cmd,
	input  logic                       cmd_pop
);

	gbn_pkg::cmd_t                    queue_q [gbn_pkg::QUEUE_DEPTH];
	logic [gbn_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [gbn_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [gbn_pkg::QCNT_W-1:0]       count_q;
	gbn_pkg::cmd_t                    classified;
	logic                             push;
	logic                             pop;

	// Classify the event and clamp the chunk length
	always_comb begin
		classified.word = chunk_word;
		classified.ack  = ack_number;
		classified.len  = (chunk_len > gbn_pkg::CHUNK_MAX) ? gbn_pkg::CHUNK_MAX : chunk_len;
		case (op)
			gbn_pkg::OP_SEND:    classified.kind = gbn_pkg::CMD_SEND;
			gbn_pkg::OP_ACK:     classified.kind = gbn_pkg::CMD_ACK;
			gbn_pkg::OP_TIMEOUT: classified.kind = gbn_pkg::CMD_TIMEOUT;
			default:             classified.kind = gbn_pkg::CMD_NOP;
		endcase
	end

	assign evt_stall = (count_q == gbn_pkg::QCNT_W'(gbn_pkg::QUEUE_DEPTH));
	assign push      = evt_valid && !evt_stall;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = queue_q[rd_ptr_q];

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Queue payload
	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= classified;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= gbn_pkg::QCNT_W'(gbn_pkg::QUEUE_DEPTH))
		else $error("queue fill count past depth");

endmodule

>>> hw/rtl/gbn_back.sv
// Back end: window state, packet store, replay sequencer and result register.
module gbn_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  gbn_pkg::cmd_t               cmd,
	output logic                        cmd_pop,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [gbn_pkg::WIN_W-1:0]   cfg_data,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic                        send_valid,
	output logic [gbn_pkg::SEQ_W-1:0]   seq_number,
	output logic [gbn_pkg::WORD_W-1:0]  out_word,
	output logic [gbn_pkg::LEN_W-1:0]   out_len,
	output logic [1:0]                  timer_cmd,
	output logic [1:0]                  status,
	output logic                        last
);

	localparam int SEQ_W   = gbn_pkg::SEQ_W;
	localparam int SLOT_W  = gbn_pkg::SLOT_W;
	localparam int CNT_W   = gbn_pkg::CNT_W;
	localparam int WIN_W   = gbn_pkg::WIN_W;
	localparam int LEN_W   = gbn_pkg::LEN_W;
	localparam int WORD_W  = gbn_pkg::WORD_W;
	localparam int RETRY_W = gbn_pkg::RETRY_W;
	localparam int ENTRY_W = gbn_pkg::ENTRY_W;

	// Configuration
	logic [WIN_W-1:0]   win_size_q;
	logic [RETRY_W-1:0] retry_limit_q;

	// Window state
	logic [SEQ_W-1:0]   base_q;
	logic [SEQ_W-1:0]   next_seq_q;
	logic [SLOT_W-1:0]  base_slot_q;
	logic [RETRY_W-1:0] retry_q;
	logic               failed_q;

	// Replay sequencer
	gbn_pkg::state_t    state_q;
	gbn_pkg::state_t    state_d;
	logic [CNT_W-1:0]   rep_idx_q;
	logic               rep_fail_q;

	// Packet store
	logic [ENTRY_W-1:0] sent_mem [gbn_pkg::WINDOW_MAX];
	logic [ENTRY_W-1:0] mem_rd_q;

	// Result register
	logic               res_valid_q;
	logic               send_valid_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [WORD_W-1:0]  word_q;
	logic [LEN_W-1:0]   len_q;
	gbn_pkg::timer_t    timer_q;
	gbn_pkg::status_t   status_q;
	logic               last_q;

	// Derived values
	logic [SEQ_W-1:0]   outstanding;
	logic [CNT_W-1:0]   out_cnt;
	logic [WIN_W-1:0]   eff_win;
	logic [SEQ_W-1:0]   ack_off;
	logic [SEQ_W-1:0]   ack_next;
	logic [CNT_W-1:0]   idx_next;
	logic               rep_fin;
	logic               out_free;

	// Control decisions
	logic               ld;
	logic               ld_send;
	logic [SEQ_W-1:0]   ld_seq;
	logic [WORD_W-1:0]  ld_word;
	logic [LEN_W-1:0]   ld_len;
	gbn_pkg::timer_t    ld_timer;
	gbn_pkg::status_t   ld_status;
	logic               ld_last;
	logic               wr_en;
	logic [SLOT_W-1:0]  wr_slot;
	logic               rd_en;
	logic [SLOT_W-1:0]  rd_slot;
	logic               do_send;
	logic               do_ack;
	logic               rep_start;
	logic               rep_step;

	assign cfg_ready   = 1'b1;
	assign outstanding = next_seq_q - base_q;
	assign out_cnt     = outstanding[CNT_W-1:0];
	assign ack_off     = cmd.ack - base_q;
	assign ack_next    = cmd.ack + 1'b1;
	assign idx_next    = rep_idx_q + 1'b1;
	assign rep_fin     = (idx_next == out_cnt);
	assign out_free    = !res_valid_q || !res_stall;

	// Effective window: zero acts as one, clamp at store depth
	always_comb begin
		if (win_size_q == '0)
			eff_win = WIN_W'(1);
		else if (win_size_q > WIN_W'(gbn_pkg::WINDOW_MAX))
			eff_win = WIN_W'(gbn_pkg::WINDOW_MAX);
		else
			eff_win = win_size_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gbn_pkg::S_IDLE: begin
				if (rep_start) state_d = gbn_pkg::S_REPLAY;
			end
			gbn_pkg::S_REPLAY: begin
				if (rep_step && rep_fin) state_d = gbn_pkg::S_IDLE;
			end
			default: state_d = gbn_pkg::S_IDLE;
		endcase
	end

	// Command execution and result selection
	always_comb begin
		cmd_pop   = 1'b0;
		ld        = 1'b0;
		ld_send   = 1'b0;
		ld_seq    = '0;
		ld_word   = '0;
		ld_len    = '0;
		ld_timer  = gbn_pkg::TMR_LEAVE;
		ld_status = gbn_pkg::STS_OK;
		ld_last   = 1'b1;
		wr_en     = 1'b0;
		wr_slot   = base_slot_q + outstanding[SLOT_W-1:0];
		rd_en     = 1'b0;
		rd_slot   = base_slot_q;
		do_send   = 1'b0;
		do_ack    = 1'b0;
		rep_start = 1'b0;
		rep_step  = 1'b0;
		case (state_q)
			gbn_pkg::S_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					ld      = 1'b1;
					if (failed_q) begin
						ld_status = gbn_pkg::STS_FAIL;
					end else begin
						case (cmd.kind)
							gbn_pkg::CMD_SEND: begin
								if (outstanding >= {{(SEQ_W-WIN_W){1'b0}}, eff_win}) begin
									ld_status = gbn_pkg::STS_FULL;
								end else begin
									do_send  = 1'b1;
									wr_en    = 1'b1;
									ld_send  = 1'b1;
									ld_seq   = next_seq_q;
									ld_word  = cmd.word;
									ld_len   = cmd.len;
									ld_timer = (outstanding == '0) ? gbn_pkg::TMR_ARM
									                               : gbn_pkg::TMR_LEAVE;
								end
							end
							gbn_pkg::CMD_ACK: begin
								if (ack_off >= outstanding) begin
									ld_status = gbn_pkg::STS_IGNORED;
								end else begin
									do_ack   = 1'b1;
									ld_timer = (ack_next == next_seq_q) ? gbn_pkg::TMR_STOP
									                                    : gbn_pkg::TMR_LEAVE;
								end
							end
							gbn_pkg::CMD_TIMEOUT: begin
								// Start replay: first store read now, results follow
								if (outstanding != '0) begin
									ld        = 1'b0;
									rep_start = 1'b1;
									rd_en     = 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
			end
			gbn_pkg::S_REPLAY: begin
				if (out_free) begin
					rep_step = 1'b1;
					ld       = 1'b1;
					ld_send  = 1'b1;
					ld_seq   = base_q + {{(SEQ_W-CNT_W){1'b0}}, rep_idx_q};
					ld_word  = mem_rd_q[LEN_W +: WORD_W];
					ld_len   = mem_rd_q[LEN_W-1:0];
					ld_last  = rep_fin;
					if (rep_fail_q && rep_fin) begin
						ld_timer  = gbn_pkg::TMR_STOP;
						ld_status = gbn_pkg::STS_FAIL;
					end else if (!rep_fail_q && rep_idx_q == '0) begin
						ld_timer  = gbn_pkg::TMR_ARM;
					end
					// Prefetch the next outstanding entry
					rd_en   = !rep_fin;
					rd_slot = base_slot_q + idx_next[SLOT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q    <= gbn_pkg::WIN_RESET;
			retry_limit_q <= gbn_pkg::RETRY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gbn_pkg::REG_WIN_LIMIT:   win_size_q    <= cfg_data;
				gbn_pkg::REG_RETRY_LIMIT: retry_limit_q <= cfg_data[RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	// Window state and replay control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gbn_pkg::S_IDLE;
			base_q      <= '0;
			next_seq_q  <= '0;
			base_slot_q <= '0;
			retry_q     <= '0;
			failed_q    <= 1'b0;
			rep_idx_q   <= '0;
			rep_fail_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_send) begin
				next_seq_q <= next_seq_q + 1'b1;
				retry_q    <= '0;
			end
			if (do_ack) begin
				base_q      <= ack_next;
				base_slot_q <= base_slot_q + ack_off[SLOT_W-1:0] + 1'b1;
			end
			if (rep_start) begin
				rep_idx_q  <= '0;
				rep_fail_q <= (retry_q >= retry_limit_q);
			end
			if (rep_step) begin
				rep_idx_q <= idx_next;
				if (rep_fin) begin
					if (retry_q != gbn_pkg::RETRY_SAT) retry_q <= retry_q + 1'b1;
					if (rep_fail_q) failed_q <= 1'b1;
				end
			end
		end
	end

	// Packet store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) sent_mem[wr_slot] <= {ld_word, ld_len};
		if (rd_en) mem_rd_q <= sent_mem[rd_slot];
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ld) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (ld) begin
			send_valid_q <= ld_send;
			seq_q        <= ld_seq;
			word_q       <= ld_word;
			len_q        <= ld_len;
			timer_q      <= ld_timer;
			status_q     <= ld_status;
			last_q       <= ld_last;
		end
	end

	assign res_valid  = res_valid_q;
	assign send_valid = send_valid_q;
	assign seq_number = seq_q;
	assign out_word   = word_q;
	assign out_len    = len_q;
	assign timer_cmd  = timer_q;
	assign status     = status_q;
	assign last       = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		outstanding <= SEQ_W'(gbn_pkg::WINDOW_MAX))
		else $error("outstanding count beyond store depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gbn_pkg::S_REPLAY) |-> (!failed_q && out_cnt != '0 && rep_idx_q < out_cnt))
		else $error("replay index out of outstanding range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rep_step && rep_fin) |=> (state_q == gbn_pkg::S_IDLE && res_valid_q && last_q))
		else $error("replay did not end on a final result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gbn_pkg::S_REPLAY) |-> !cmd_pop)
		else $error("command taken during replay");

endmodule

>>> hw/rtl/go_back_n_sender_window.sv
// Top level of the go-back-N sender window: front end, command queue and back end.
// An event is written into the command queue; the back end then loads the result register
// from the queue head, and a replayed packet first passes through the registered store read.
// Throughput: one send, ack, empty timeout or failed event per cycle unless stalled.
// A replay holds the back end: a store read, then one packet per cycle unless stalled.
// Reset: window empty, counters and failure cleared, window limit 4, retry limit 10.
module go_back_n_sender_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       evt_valid,
	output logic                       evt_stall,
	input  logic [1:0]                 op,
	input  logic [gbn_pkg::WORD_W-1:0] chunk_word,
	input  logic [gbn_pkg::LEN_W-1:0]  chunk_len,
	input  logic [gbn_pkg::SEQ_W-1:0]  ack_number,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [gbn_pkg::WIN_W-1:0]  cfg_data,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic                       send_valid,
	output logic [gbn_pkg::SEQ_W-1:0]  seq_number,
	output logic [gbn_pkg::WORD_W-1:0] out_word,
	output logic [gbn_pkg::LEN_W-1:0]  out_len,
	output logic [1:0]                 timer_cmd,
	output logic [1:0]                 status,
	output logic                       last
);

	logic          cmd_valid;
	logic          cmd_pop;
	gbn_pkg::cmd_t cmd;

	gbn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt_valid  (evt_valid),
		.evt_stall  (evt_stall),
		.op         (op),
		.chunk_word (chunk_word),
		.chunk_len  (chunk_len),
		.ack_number (ack_number),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	gbn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.send_valid (send_valid),
		.seq_number (seq_number),
		.out_word   (out_word),
		.out_len    (out_len),
		.timer_cmd  (timer_cmd),
		.status     (status),
		.last       (last)
	);

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the go-back-N sender window: directed and random events.
module tb_top;

	localparam int SEQ_W       = gbn_pkg::SEQ_W;
	localparam int WORD_W      = gbn_pkg::WORD_W;
	localparam int LEN_W       = gbn_pkg::LEN_W;
	localparam int WIN_W       = gbn_pkg::WIN_W;
	localparam int RETRY_W     = gbn_pkg::RETRY_W;
	localparam int SLOT_W      = gbn_pkg::SLOT_W;
	localparam int WINDOW_MAX  = gbn_pkg::WINDOW_MAX;
	localparam int CYCLE_LIMIT = 200000;

	// Op code with no event kind behind it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// One expected result of the sender window
	typedef struct {
		logic              send_valid;
		logic [SEQ_W-1:0]  seq;
		logic [WORD_W-1:0] word;
		logic [LEN_W-1:0]  len;
		gbn_pkg::timer_t   tcmd;
		gbn_pkg::status_t  sts;
		logic              fin;
	} tx_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_stall;
	logic [1:0] op = 2'd0;
	logic [WORD_W-1:0] chunk_word = '0;
	logic [LEN_W-1:0] chunk_len = '0;
	logic [SEQ_W-1:0] ack_number = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [WIN_W-1:0] cfg_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic send_valid;
	logic [SEQ_W-1:0] seq_number;
	logic [WORD_W-1:0] out_word;
	logic [LEN_W-1:0] out_len;
	logic [1:0] timer_cmd;
	logic [1:0] status;
	logic last;

	// Sender window mirror
	logic [SEQ_W-1:0] win_base;
	logic [SEQ_W-1:0] next_seq;
	logic [RETRY_W-1:0] retry_run;
	logic sender_failed;
	logic [SLOT_W-1:0] ring_head;
	logic [WORD_W-1:0] ring_word [WINDOW_MAX];
	logic [LEN_W-1:0] ring_len [WINDOW_MAX];
	logic [WIN_W-1:0] cfg_window;
	logic [RETRY_W-1:0] cfg_retry;

	tx_result_t awaited_results [$];
	int mismatch_count = 0;
	int events_done = 0;
	int results_seen = 0;
	int replays_done = 0;
	bit quiet = 1'b0;
	int stall_left = 0;
	int unsigned cycle_count = 0;

	go_back_n_sender_window dut (
		.clk(clk), .arst_n(arst_n),
		.evt_valid(evt_valid), .evt_stall(evt_stall),
		.op(op), .chunk_word(chunk_word), .chunk_len(chunk_len), .ack_number(ack_number),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.res_valid(res_valid), .res_stall(res_stall),
		.send_valid(send_valid), .seq_number(seq_number), .out_word(out_word),
		.out_len(out_len), .timer_cmd(timer_cmd), .status(status), .last(last)
	);

	// Clock: period 4
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				awaited_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Random receiver stall bursts, none in the quiet tail
	always @(posedge clk) begin
		if (quiet) begin
			res_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			res_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			res_stall <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			res_stall <= 1'b0;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic logic [SEQ_W-1:0] rand_seq();
		return SEQ_W'($urandom);
	endfunction

	function automatic logic [LEN_W-1:0] rand_len();
		return LEN_W'($urandom);
	endfunction

	function automatic void push_result(input logic sv, input logic [SEQ_W-1:0] seq,
		input logic [WORD_W-1:0] word, input logic [LEN_W-1:0] len,
		input gbn_pkg::timer_t tcmd, input gbn_pkg::status_t sts, input logic fin);
		tx_result_t r;
		r.send_valid = sv;
		r.seq = seq;
		r.word = word;
		r.len = len;
		r.tcmd = tcmd;
		r.sts = sts;
		r.fin = fin;
		awaited_results.push_back(r);
	endfunction

	// Result with no packet attached
	function automatic void push_plain(input gbn_pkg::timer_t tcmd,
		input gbn_pkg::status_t sts);
		push_result(1'b0, '0, '0, '0, tcmd, sts, 1'b1);
	endfunction

	// Work out the results of one event and advance the mirrored window
	function automatic void apply_window_event(input logic [1:0] ev_op,
		input logic [WORD_W-1:0] word, input logic [LEN_W-1:0] len,
		input logic [SEQ_W-1:0] ackn);
		logic [SEQ_W-1:0] in_flight;
		logic [SEQ_W-1:0] offset;
		logic [WIN_W-1:0] win_eff;
		logic [SLOT_W-1:0] slot;
		bit give_up;
		bit fin;
		gbn_pkg::timer_t tcmd;
		in_flight = next_seq - win_base;
		if (cfg_window == '0)
			win_eff = WIN_W'(1);
		else if (cfg_window > WIN_W'(WINDOW_MAX))
			win_eff = WIN_W'(WINDOW_MAX);
		else
			win_eff = cfg_window;
		if (sender_failed) begin
			push_plain(gbn_pkg::TMR_LEAVE, gbn_pkg::STS_FAIL);
			return;
		end
		case (ev_op)
			gbn_pkg::OP_SEND: begin
				if (in_flight >= {{(SEQ_W-WIN_W){1'b0}}, win_eff}) begin
					push_plain(gbn_pkg::TMR_LEAVE, gbn_pkg::STS_FULL);
				end else begin
					if (len > gbn_pkg::CHUNK_MAX)
						len = gbn_pkg::CHUNK_MAX;
					slot = ring_head + in_flight[SLOT_W-1:0];
					ring_word[slot] = word;
					ring_len[slot] = len;
					push_result(1'b1, next_seq, word, len,
						(in_flight == '0) ? gbn_pkg::TMR_ARM : gbn_pkg::TMR_LEAVE,
						gbn_pkg::STS_OK, 1'b1);
					next_seq = next_seq + 1'b1;
					retry_run = '0;
				end
			end
			gbn_pkg::OP_ACK: begin
				offset = ackn - win_base;
				if (offset >= in_flight) begin
					push_plain(gbn_pkg::TMR_LEAVE, gbn_pkg::STS_IGNORED);
				end else begin
					win_base = ackn + 1'b1;
					ring_head = ring_head + offset[SLOT_W-1:0] + 1'b1;
					push_plain((win_base == next_seq) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_LEAVE,
						gbn_pkg::STS_OK);
				end
			end
			gbn_pkg::OP_TIMEOUT: begin
				if (in_flight == '0) begin
					push_plain(gbn_pkg::TMR_LEAVE, gbn_pkg::STS_OK);
				end else begin
					// replay the whole window, oldest first
					give_up = (retry_run >= cfg_retry);
					for (int k = 0; k < int'(in_flight); k++) begin
						slot = ring_head + SLOT_W'(k);
						fin = (k == int'(in_flight) - 1);
						tcmd = gbn_pkg::TMR_LEAVE;
						if (give_up && fin)
							tcmd = gbn_pkg::TMR_STOP;
						else if (!give_up && k == 0)
							tcmd = gbn_pkg::TMR_ARM;
						push_result(1'b1, win_base + SEQ_W'(k), ring_word[slot], ring_len[slot],
							tcmd, (give_up && fin) ? gbn_pkg::STS_FAIL : gbn_pkg::STS_OK, fin);
					end
					if (retry_run != gbn_pkg::RETRY_SAT)
						retry_run = retry_run + 1'b1;
					if (give_up)
						sender_failed = 1'b1;
					replays_done++;
				end
			end
			default: begin
				push_plain(gbn_pkg::TMR_LEAVE, gbn_pkg::STS_OK);
			end
		endcase
	endfunction

	// Result checker: each transfer against the oldest expectation
	always @(posedge clk) begin
		tx_result_t want;
		if (arst_n && res_valid === 1'b1 && !res_stall) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result seq %0h status %0d",
					seq_number, status));
			end else begin
				want = awaited_results.pop_front();
				check_field("send_valid", 32'(send_valid), 32'(want.send_valid));
				check_field("seq_number", 32'(seq_number), 32'(want.seq));
				check_field("out_word", out_word, want.word);
				check_field("out_len", 32'(out_len), 32'(want.len));
				check_field("timer_cmd", 32'(timer_cmd), 32'(want.tcmd));
				check_field("status", 32'(status), 32'(want.sts));
				check_field("last", 32'(last), 32'(want.fin));
			end
		end
	end

	// One event transfer, with an optional sender gap in front
	task automatic send_event(input logic [1:0] ev_op, input logic [WORD_W-1:0] word,
		input logic [LEN_W-1:0] len, input logic [SEQ_W-1:0] ackn);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			evt_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		evt_valid <= 1'b1;
		op <= ev_op;
		chunk_word <= word;
		chunk_len <= len;
		ack_number <= ackn;
		do @(posedge clk); while (evt_stall);
		apply_window_event(ev_op, word, len, ackn);
		events_done++;
	endtask

	// Let every expected result come out, then let the outputs settle
	task automatic wait_drained();
		evt_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input gbn_pkg::reg_idx_t idx, input logic [WIN_W-1:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == gbn_pkg::REG_WIN_LIMIT)
			cfg_window = val;
		else
			cfg_retry = val[RETRY_W-1:0];
	endtask

	function automatic logic [LEN_W-1:0] pick_len();
		if ($urandom_range(0, 9) == 0)
			return LEN_W'($urandom_range(1025, 2047));
		return LEN_W'($urandom_range(0, 1024));
	endfunction

	// Default window of 4: fill it, then one refused chunk; length extremes
	task automatic test_send_window();
		send_event(gbn_pkg::OP_SEND, 32'h0000_0000, 11'd0, rand_seq());
		send_event(gbn_pkg::OP_SEND, 32'hFFFF_FFFF, 11'd1024, rand_seq());
		send_event(gbn_pkg::OP_SEND, 32'hA5A5_5A5A, 11'd2047, rand_seq());
		send_event(gbn_pkg::OP_SEND, $urandom, 11'd1, rand_seq());
		send_event(gbn_pkg::OP_SEND, $urandom, pick_len(), rand_seq());
	endtask

	// Ignored and accepted acks, replay, empty timeout, unused op code
	task automatic test_ack_and_timer();
		send_event(gbn_pkg::OP_ACK, $urandom, rand_len(), 16'hFFFF);
		send_event(gbn_pkg::OP_ACK, $urandom, rand_len(), next_seq);
		send_event(gbn_pkg::OP_ACK, $urandom, rand_len(), win_base + 1'b1);
		send_event(gbn_pkg::OP_TIMEOUT, $urandom, rand_len(), rand_seq());
		send_event(gbn_pkg::OP_ACK, $urandom, rand_len(), next_seq - 1'b1);
		send_event(gbn_pkg::OP_TIMEOUT, $urandom, rand_len(), rand_seq());
		send_event(OP_UNUSED, $urandom, rand_len(), rand_seq());
	endtask

	// Window size 0 acts as a window of one
	task automatic test_window_zero();
		write_reg(gbn_pkg::REG_WIN_LIMIT, 5'd0);
		send_event(gbn_pkg::OP_SEND, $urandom, pick_len(), rand_seq());
		send_event(gbn_pkg::OP_SEND, $urandom, pick_len(), rand_seq());
		send_event(gbn_pkg::OP_TIMEOUT, $urandom, rand_len(), rand_seq());
		send_event(gbn_pkg::OP_ACK, $urandom, rand_len(), next_seq - 1'b1);
	endtask

	// Timeouts up to the retry limit, cleared by a new chunk
	task automatic test_retry_count();
		write_reg(gbn_pkg::REG_WIN_LIMIT, 5'd31);
		write_reg(gbn_pkg::REG_RETRY_LIMIT, 5'd2);
		send_event(gbn_pkg::OP_SEND, $urandom, pick_len(), rand_seq());
		send_event(gbn_pkg::OP_TIMEOUT, $urandom, rand_len(), rand_seq());
		send_event(gbn_pkg::OP_TIMEOUT, $urandom, rand_len(), rand_seq());
		send_event(gbn_pkg::OP_SEND, $urandom, pick_len(), rand_seq());
		send_event(gbn_pkg::OP_TIMEOUT, $urandom, rand_len(), rand_seq());
		send_event(gbn_pkg::OP_TIMEOUT, $urandom, rand_len(), rand_seq());
		send_event(gbn_pkg::OP_ACK, $urandom, rand_len(), next_seq - 1'b1);
	endtask

	// Random mix: mostly sends and in-range acks, some timeouts and noise
	task automatic test_random_traffic(input int count, input int send_pct);
		logic [SEQ_W-1:0] in_flight;
		logic [SEQ_W-1:0] ackn;
		int pick;
		repeat (count) begin
			in_flight = next_seq - win_base;
			pick = $urandom_range(0, 99);
			if (pick < send_pct) begin
				send_event(gbn_pkg::OP_SEND, $urandom, pick_len(), rand_seq());
			end else if (pick < send_pct + 25) begin
				if (in_flight != '0 && $urandom_range(0, 5) != 0)
					ackn = win_base + SEQ_W'($urandom_range(0, int'(in_flight) - 1));
				else if ($urandom_range(0, 1) == 0)
					ackn = win_base - 1'b1;
				else
					ackn = rand_seq();
				send_event(gbn_pkg::OP_ACK, $urandom, pick_len(), ackn);
			end else if (pick < send_pct + 33) begin
				send_event(gbn_pkg::OP_TIMEOUT, $urandom, pick_len(), rand_seq());
			end else begin
				send_event(2'($urandom_range(0, 3)), $urandom, rand_len(), rand_seq());
			end
		end
	endtask

	// Retry limit 0 (written as 16): the first replay fails, then the sender stays failed
	task automatic test_sticky_failure();
		write_reg(gbn_pkg::REG_RETRY_LIMIT, 5'd16);
		send_event(gbn_pkg::OP_SEND, $urandom, pick_len(), rand_seq());
		send_event(gbn_pkg::OP_TIMEOUT, $urandom, rand_len(), rand_seq());
		send_event(gbn_pkg::OP_SEND, $urandom, pick_len(), rand_seq());
		send_event(gbn_pkg::OP_ACK, $urandom, rand_len(), win_base);
		send_event(gbn_pkg::OP_TIMEOUT, $urandom, rand_len(), rand_seq());
		send_event(OP_UNUSED, $urandom, rand_len(), rand_seq());
	endtask

	initial begin
		win_base = '0;
		next_seq = '0;
		retry_run = '0;
		sender_failed = 1'b0;
		ring_head = '0;
		cfg_window = gbn_pkg::WIN_RESET;
		cfg_retry = gbn_pkg::RETRY_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_send_window();
		test_ack_and_timer();
		test_window_zero();
		test_retry_count();

		write_reg(gbn_pkg::REG_RETRY_LIMIT, 5'd15);
		write_reg(gbn_pkg::REG_WIN_LIMIT, 5'($urandom_range(1, 16)));
		test_random_traffic(90, 55);
		write_reg(gbn_pkg::REG_WIN_LIMIT, 5'd31);
		test_random_traffic(90, 65);
		write_reg(gbn_pkg::REG_WIN_LIMIT, 5'd2);
		test_random_traffic(80, 55);
		write_reg(gbn_pkg::REG_WIN_LIMIT, 5'd16);
		quiet = 1'b1;
		test_random_traffic(80, 60);
		test_sticky_failure();

		wait_drained();
		$display("Ran %0d events, checked %0d results, %0d timeout replays.",
			events_done, results_seen, replays_done);
		$display("Window limits 0, 2, 16, 31 and one random size; retry limits 0, 2, 10, 15.");
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
